>>> design/cmgd_pkg.sv
// ----------------------------------------------------------------------------
// cmgd_pkg: shared constants, types and tables of the multi-turn gear decoder
// Tooth counts, field widths, inverse tables, reciprocals and CRT weights.
// ----------------------------------------------------------------------------
package cmgd_pkg;

  // Gear geometry and sensor format
  localparam int P_ONE       = 17;
  localparam int P_TWO       = 19;
  localparam int P_THREE     = 23;
  localparam int ANGLE_BITS  = 14;
  localparam int RAW_ANGLE_W = 14;
  localparam int NUM_LANES   = 3;
  localparam int LANE_IDX_W  = $clog2(NUM_LANES);
  localparam int TEETH_BITS  = 6;

  // Field and register widths
  localparam int SUN_BITS      = 8;
  localparam int SUN_RANGE     = 1 << SUN_BITS;
  localparam int JUMP_BITS     = 13;
  localparam int TURN_CNT_BITS = 13;
  localparam int CFG_DATA_W    = (SUN_BITS > JUMP_BITS) ? SUN_BITS : JUMP_BITS;
  localparam int CFG_IDX_W     = 1;

  localparam logic [SUN_BITS-1:0]  SUN_RESET  = SUN_BITS'(1);
  localparam logic [JUMP_BITS-1:0] JUMP_RESET = JUMP_BITS'(3714);

  // Turn range
  localparam int TURN_RANGE = P_ONE * P_TWO * P_THREE;
  localparam int HALF_RANGE = TURN_RANGE / 2;
  localparam int TURN_W     = $clog2(TURN_RANGE);
  localparam int DIFF_W     = TURN_W + 1;
  localparam int GUARD_W    = (TURN_W > JUMP_BITS) ? TURN_W : JUMP_BITS;

  // Tooth rounding
  localparam int FULL_CIRCLE = 1 << ANGLE_BITS;
  localparam int ROUND_W     = ((RAW_ANGLE_W > ANGLE_BITS) ? RAW_ANGLE_W : ANGLE_BITS)
                               + TEETH_BITS + 1;
  localparam logic [RAW_ANGLE_W-1:0] ANGLE_MASK =
    RAW_ANGLE_W'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [ROUND_W-1:0] HALF_CIRCLE = ROUND_W'(FULL_CIRCLE / 2);

  // Modular inverse of v modulo m, or 0 if none; elaboration only.
  function automatic int inv_mod(input int v, input int m);
    int r;
    int acc;
    int res;
    r   = v;
    acc = 0;
    res = 0;
    if (m >= 2) begin
      while (r >= m) r = r - m;
      for (int c = 1; c < m; c++) begin
        acc = acc + r;
        if (acc >= m) acc = acc - m;
        if (acc == 1 && res == 0) res = c;
      end
    end
    return res;
  endfunction

  localparam bit PLANETS_OK = (inv_mod(P_ONE, P_TWO) != 0) &&
                              (inv_mod(P_ONE, P_THREE) != 0) &&
                              (inv_mod(P_TWO, P_THREE) != 0);

  // Inverse of every sun tooth count modulo one planet
  typedef logic [SUN_RANGE-1:0][TEETH_BITS-1:0] inv_row_t;

  function automatic inv_row_t build_inv_row(input int m);
    inv_row_t row;
    for (int v = 0; v < SUN_RANGE; v++) row[v] = TEETH_BITS'(inv_mod(v, m));
    return row;
  endfunction

  localparam logic [TEETH_BITS-1:0] LANE_MODULUS [NUM_LANES] =
    '{TEETH_BITS'(P_ONE), TEETH_BITS'(P_TWO), TEETH_BITS'(P_THREE)};

  localparam inv_row_t INV_TAB [NUM_LANES] =
    '{build_inv_row(P_ONE), build_inv_row(P_TWO), build_inv_row(P_THREE)};

  // Residue reduction by reciprocal
  localparam int LANE_SH = 2 * TEETH_BITS;
  localparam int LANE_PW = 2 * LANE_SH;
  localparam logic [LANE_SH-1:0] LANE_RECIP [NUM_LANES] =
    '{LANE_SH'((1 << LANE_SH) / P_ONE),
      LANE_SH'((1 << LANE_SH) / P_TWO),
      LANE_SH'((1 << LANE_SH) / P_THREE)};
  localparam int LANE_STAGES = 4;

  // CRT weights: E_i = 1 mod p_i, 0 mod the others
  localparam int E_W    = $clog2(TURN_RANGE * (1 << TEETH_BITS));
  localparam int SUM_W  = $clog2(NUM_LANES * TURN_RANGE * (1 << TEETH_BITS));
  localparam int SUM_PW = 2 * SUM_W;
  localparam logic [E_W-1:0] CRT_E [NUM_LANES] =
    '{E_W'((TURN_RANGE / P_ONE) * inv_mod(TURN_RANGE / P_ONE, P_ONE)),
      E_W'((TURN_RANGE / P_TWO) * inv_mod(TURN_RANGE / P_TWO, P_TWO)),
      E_W'((TURN_RANGE / P_THREE) * inv_mod(TURN_RANGE / P_THREE, P_THREE))};
  localparam logic [SUM_W-1:0] CRT_RECIP = SUM_W'((64'd1 << SUM_W) / TURN_RANGE);
  localparam int JOIN_STAGES = 3;

  // Sequencing
  localparam int WORK_CYCLES = LANE_STAGES + JOIN_STAGES;
  localparam int STEP_W      = $clog2(WORK_CYCLES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_DIST,
    S_GUARD
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUN_COUNT,
    CFG_MAX_JUMP
  } cfg_reg_t;

  typedef struct packed {
    logic                  inv_ok;
    logic [TEETH_BITS-1:0] residue;
  } lane_res_t;

  typedef logic [NUM_LANES-1:0][TEETH_BITS-1:0] residue_vec_t;

endpackage

>>> design/cmgd_in_if.sv
// ----------------------------------------------------------------------------
// cmgd_in_if: input reading channel
// Valid/ready channel carrying mode and the four sensor angles.
// ----------------------------------------------------------------------------
interface cmgd_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [cmgd_pkg::RAW_ANGLE_W-1:0] sun_angle;
  logic [cmgd_pkg::RAW_ANGLE_W-1:0] planet_one_angle;
  logic [cmgd_pkg::RAW_ANGLE_W-1:0] planet_two_angle;
  logic [cmgd_pkg::RAW_ANGLE_W-1:0] planet_three_angle;

  modport source (
    output valid, mode, sun_angle, planet_one_angle, planet_two_angle,
           planet_three_angle,
    input  ready
  );
  modport sink (
    input  valid, mode, sun_angle, planet_one_angle, planet_two_angle,
           planet_three_angle,
    output ready
  );
endinterface

>>> design/cmgd_out_if.sv
// ----------------------------------------------------------------------------
// cmgd_out_if: decoded result channel
// Valid/ready channel carrying the verdict, turn count and sun angle.
// ----------------------------------------------------------------------------
interface cmgd_out_if;
  logic                               valid;
  logic                               ready;
  logic                               valid_res;
  logic [cmgd_pkg::TURN_CNT_BITS-1:0] turn_count;
  logic [cmgd_pkg::RAW_ANGLE_W-1:0]   angle_out;

  modport source (
    output valid, valid_res, turn_count, angle_out,
    input  ready
  );
  modport sink (
    input  valid, valid_res, turn_count, angle_out,
    output ready
  );
endinterface

>>> design/cmgd_cfg_if.sv
// ----------------------------------------------------------------------------
// cmgd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cmgd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cmgd_pkg::CFG_IDX_W-1:0]  addr;
  logic [cmgd_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, addr, data,
    input  ready
  );
  modport sink (
    input  valid, addr, data,
    output ready
  );
endinterface

>>> design/crt_multiturn_gear_decoder.sv
// ----------------------------------------------------------------------------
// crt_multiturn_gear_decoder: absolute multi-turn decoder for a sun gear
// driving three planet gears, joined by the Chinese remainder theorem.
//
// in_ch  : one transfer per reading. mode 0 decodes the four angles, mode 1
//          clears the history in the transfer cycle and yields no result.
// out_ch : one transfer per mode 0 reading: valid_res, turn_count, angle_out.
// cfg_ch : register 0 sun tooth count, register 1 max_turn_jump; always
//          ready. It must be written only while the decoder is idle;
//          the block itself leaves this to the user.
// A mode 0 reading passes the three planet lanes (round, scale, quotient,
// remainder), the residue merge (weighted sum, quotient, remainder), the
// circular distance and the slew check on its way to the output register.
// The single shared lane/merge pipeline holds one reading at a time, so
// in_ch takes a new reading only once the last has left the slew stage.
// A finished result waits in the output register while the next reading
// is transferred in. If the receiver stalls, the next result waits in the
// slew stage and in_ch.ready stays low until the output register frees.
// Reset (rst_n low, synchronous) returns to idle, empties the output,
// clears the history and restores a sun tooth count of 1 and
// max_turn_jump 3714.
// ----------------------------------------------------------------------------
module crt_multiturn_gear_decoder (
  input  logic        clk,
  input  logic        rst_n,
  cmgd_in_if.sink     in_ch,
  cmgd_out_if.source  out_ch,
  cmgd_cfg_if.sink    cfg_ch
);
  import cmgd_pkg::*;

  // Configuration
  logic [SUN_BITS-1:0]  sun_cnt_r;
  logic [JUMP_BITS-1:0] max_jump_r;
  logic                 cfg_fire;

  // Sequencer
  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              in_fire;
  logic              in_rdy;
  logic              out_free;
  logic              load_out;

  // Reading held for the duration of the decode
  logic [RAW_ANGLE_W-1:0] sun_angle_r;
  logic [RAW_ANGLE_W-1:0] planet_angle_r [NUM_LANES];

  // Datapath
  lane_res_t         lane_res [NUM_LANES];
  residue_vec_t      res_vec;
  logic              geo_ok;
  logic [TURN_W-1:0] turns;
  logic [DIFF_W-1:0] fwd;
  logic [TURN_W-1:0] dist_nxt, dist_r;
  logic              rejected;
  logic              res_ok;

  // History
  logic [TURN_W-1:0] last_turns_r;
  logic              have_history_r;

  // Output register
  logic                     out_valid_r;
  logic                     out_res_ok_r;
  logic [TURN_CNT_BITS-1:0] out_turn_r;
  logic [RAW_ANGLE_W-1:0]   out_angle_r;

  assign in_fire  = in_ch.valid && in_rdy;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  // Configuration registers: always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sun_cnt_r  <= SUN_RESET;
      max_jump_r <= JUMP_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_ch.addr))
        CFG_SUN_COUNT: sun_cnt_r  <= cfg_ch.data[SUN_BITS-1:0];
        CFG_MAX_JUMP:  max_jump_r <= cfg_ch.data[JUMP_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // Capture the angles on every transfer; they hold for the whole decode
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sun_angle_r       <= in_ch.sun_angle;
      planet_angle_r[0] <= in_ch.planet_one_angle;
      planet_angle_r[1] <= in_ch.planet_two_angle;
      planet_angle_r[2] <= in_ch.planet_three_angle;
    end
  end

  // One lane per planet, then the merge
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    cmgd_lane u_lane (
      .clk      (clk),
      .lane_idx (LANE_IDX_W'(i)),
      .angle    (planet_angle_r[i]),
      .sun_cnt  (sun_cnt_r),
      .res      (lane_res[i])
    );
    assign res_vec[i] = lane_res[i].residue;
  end

  cmgd_join u_join (
    .clk      (clk),
    .residues (res_vec),
    .turns    (turns)
  );

  // Geometry holds only when the sun has an inverse modulo every planet
  always_comb begin
    geo_ok = PLANETS_OK;
    for (int i = 0; i < NUM_LANES; i++) geo_ok = geo_ok && lane_res[i].inv_ok;
  end

  // Circular distance from the last accepted count, folded to the short way
  assign fwd = (turns >= last_turns_r)
             ? DIFF_W'(turns) - DIFF_W'(last_turns_r)
             : DIFF_W'(turns) + DIFF_W'(TURN_RANGE) - DIFF_W'(last_turns_r);
  assign dist_nxt = (fwd > DIFF_W'(HALF_RANGE)) ? TURN_W'(DIFF_W'(TURN_RANGE) - fwd)
                                                : TURN_W'(fwd);

  always_ff @(posedge clk) begin
    if (state_r == S_DIST) dist_r <= dist_nxt;
  end

  // Slew guard: the first reading after a clear always passes
  assign rejected = have_history_r && (GUARD_W'(dist_r) > GUARD_W'(max_jump_r));
  assign res_ok   = geo_ok && !rejected;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && !in_ch.mode) state_nxt = S_WORK;
      S_WORK:  if (step_r == STEP_W'(WORK_CYCLES - 1)) state_nxt = S_DIST;
      S_DIST:  state_nxt = S_GUARD;
      S_GUARD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    in_rdy   = (state_r == S_IDLE);
    load_out = (state_r == S_GUARD) && out_free;
    step_nxt = (state_r == S_WORK) ? step_r + STEP_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // History: drop on a clear request, advance on an accepted reading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_turns_r   <= '0;
      have_history_r <= 1'b0;
    end else if (in_fire && in_ch.mode) begin
      have_history_r <= 1'b0;
    end else if (load_out && res_ok) begin
      last_turns_r   <= turns;
      have_history_r <= 1'b1;
    end
  end

  // Output register: hold until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_ok_r <= res_ok;
      out_turn_r   <= geo_ok ? TURN_CNT_BITS'(turns) : '0;
      out_angle_r  <= sun_angle_r;
    end
  end

  assign in_ch.ready       = in_rdy;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.valid_res  = out_res_ok_r;
  assign out_ch.turn_count = out_turn_r;
  assign out_ch.angle_out  = out_angle_r;

  // An accepted reading becomes the new reference count
  a_history_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_ok) |=> (have_history_r && (TURN_CNT_BITS'(last_turns_r) == out_turn_r)))
    else $error("history does not track the accepted turn count");

  // The merge always lands inside the turn range
  a_turns_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (turns < TURN_W'(TURN_RANGE)))
    else $error("decoded turn count outside the turn range");

  // A clear request empties the history and starts no decode
  a_clear_drops : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.mode) |=> (!have_history_r && (state_r == S_IDLE)))
    else $error("clear request did not drop the history");

endmodule

>>> design/cmgd_lane.sv
// ----------------------------------------------------------------------------
// cmgd_lane: per-planet residue lane
// Round a planet angle to a tooth index, scale by the sun inverse, reduce.
// ----------------------------------------------------------------------------
module cmgd_lane (
  input  logic                             clk,
  input  logic [cmgd_pkg::LANE_IDX_W-1:0]  lane_idx,
  input  logic [cmgd_pkg::RAW_ANGLE_W-1:0] angle,
  input  logic [cmgd_pkg::SUN_BITS-1:0]    sun_cnt,
  output cmgd_pkg::lane_res_t              res
);
  import cmgd_pkg::*;

  logic [TEETH_BITS-1:0] teeth;
  logic [LANE_SH-1:0]    recip;

  logic [ROUND_W-1:0]    round_sum;
  logic [TEETH_BITS:0]   near;
  logic [TEETH_BITS-1:0] inv;
  logic [TEETH_BITS-1:0] tooth_nxt, tooth_r, inv_r;
  logic                  ok1_r, ok2_r, ok3_r;
  logic [LANE_SH-1:0]    prod_nxt, prod_r, prod3_r;
  logic [LANE_PW-1:0]    qfull;
  logic [LANE_SH-1:0]    quot_r;
  logic [LANE_SH-1:0]    rem;
  lane_res_t             res_nxt, res_r;

  assign teeth = LANE_MODULUS[lane_idx];
  assign recip = LANE_RECIP[lane_idx];

  // Stage 1: nearest tooth, wrapped once, and the sun inverse
  assign round_sum = ROUND_W'(angle & ANGLE_MASK) * ROUND_W'(teeth) + HALF_CIRCLE;
  assign near      = round_sum[ANGLE_BITS +: TEETH_BITS + 1];
  assign tooth_nxt = (near >= {1'b0, teeth}) ? TEETH_BITS'(near - {1'b0, teeth})
                                             : TEETH_BITS'(near);
  assign inv       = INV_TAB[lane_idx][sun_cnt];

  // Stage 2: tooth times inverse
  assign prod_nxt = LANE_SH'(tooth_r) * LANE_SH'(inv_r);

  // Stage 3: quotient estimate, low by at most one
  assign qfull = LANE_PW'(prod_r) * LANE_PW'(recip);

  // Stage 4: remainder with one correction
  assign rem = prod3_r - LANE_SH'(quot_r * LANE_SH'(teeth));
  always_comb begin
    res_nxt.inv_ok  = ok3_r;
    res_nxt.residue = (rem >= LANE_SH'(teeth)) ? TEETH_BITS'(rem - LANE_SH'(teeth))
                                               : TEETH_BITS'(rem);
  end

  always_ff @(posedge clk) begin
    tooth_r <= tooth_nxt;
    inv_r   <= inv;
    ok1_r   <= (inv != '0);
    prod_r  <= prod_nxt;
    ok2_r   <= ok1_r;
    quot_r  <= qfull[LANE_PW-1:LANE_SH];
    prod3_r <= prod_r;
    ok3_r   <= ok2_r;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

>>> design/cmgd_join.sv
// ----------------------------------------------------------------------------
// cmgd_join: residue merge
// Weight the three residues, sum, and reduce modulo the turn range.
// ----------------------------------------------------------------------------
module cmgd_join (
  input  logic                          clk,
  input  cmgd_pkg::residue_vec_t        residues,
  output logic [cmgd_pkg::TURN_W-1:0]   turns
);
  import cmgd_pkg::*;

  logic [SUM_W-1:0]  sum_nxt, sum_r, sum2_r;
  logic [SUM_PW-1:0] qfull;
  logic [SUM_W-1:0]  quot_r;
  logic [SUM_W-1:0]  rem;
  logic [TURN_W-1:0] turns_nxt, turns_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_nxt = sum_nxt + SUM_W'(residues[i]) * SUM_W'(CRT_E[i]);
    end
  end

  // Quotient estimate is low by at most one
  assign qfull = SUM_PW'(sum_r) * SUM_PW'(CRT_RECIP);

  assign rem       = sum2_r - SUM_W'(quot_r * SUM_W'(TURN_RANGE));
  assign turns_nxt = (rem >= SUM_W'(TURN_RANGE)) ? TURN_W'(rem - SUM_W'(TURN_RANGE))
                                                 : TURN_W'(rem);

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    quot_r  <= qfull[SUM_PW-1:SUM_W];
    sum2_r  <= sum_r;
    turns_r <= turns_nxt;
  end

  assign turns = turns_r;

endmodule
